### rtl/core/pdc_pkg.sv
// Shared types, constants and helper functions for the PID drive controller.
// No dependencies; every other file of the block imports this package.
package pdc_pkg;

  // Field widths
  localparam int POS_W   = 32;
  localparam int SPD_W   = 16;
  localparam int TGT_W   = 21;
  localparam int GAIN_W  = 24;
  localparam int ZONE_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Product and sum widths
  localparam int PROD_W  = GAIN_W + 1 + POS_W;      // signed gain * 32-bit error
  localparam int DPROD_W = GAIN_W + 1 + POS_W + 1;  // signed gain * 33-bit delta
  localparam int DRIFT_W = GAIN_W + POS_W + 1;      // unsigned gain * 33-bit |delta|
  localparam int ACC_W   = DPROD_W + 2;
  localparam int FRAC_SHIFT = 12;                   // 20 fraction bits down to Q8.8
  localparam int SPD_WIDE_W = ACC_W - FRAC_SHIFT;
  localparam int SUM_W      = SPD_WIDE_W + 2;

  // Controller constants
  localparam int RAMP_STEP    = 20;
  localparam int DRIVE_THRESH = 500;
  localparam int TURN_THRESH  = 800;
  localparam int DRIVE_CAP    = 80 * 256;
  localparam int TURN_CAP     = 85 * 256;
  localparam int RAMP_STEP_Q  = RAMP_STEP * 256;
  localparam int ROUND_HALF   = 1 << (FRAC_SHIFT - 1);

  // Register reset values
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 24'd162529;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 24'd105;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 24'd0;
  localparam logic [ZONE_W-1:0] INTEG_ZONE_RST = 16'd10;
  localparam logic [GAIN_W-1:0] DRIFT_GAIN_RST = 24'd104858;

  // Operating modes
  localparam logic MODE_DRIVE = 1'b0;
  localparam logic MODE_TURN  = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_TARGET     = 3'd1,
    REG_PROP_GAIN  = 3'd2,
    REG_INTEG_GAIN = 3'd3,
    REG_DERIV_GAIN = 3'd4,
    REG_INTEG_ZONE = 3'd5,
    REG_DRIFT_GAIN = 3'd6
  } cfg_reg_t;

  // Live configuration
  typedef struct packed {
    logic              mode;
    logic [TGT_W-1:0]  target;
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [ZONE_W-1:0] integ_zone;
    logic [GAIN_W-1:0] drift_gain;
  } cfg_t;

  // Error stage result
  typedef struct packed {
    logic             done;
    logic             ramp;
    logic [POS_W-1:0] err;
    logic [POS_W-1:0] err_sum;
    logic [POS_W:0]   err_delta;
    logic [POS_W:0]   drift_abs;
  } err_t;

  // Product stage result
  typedef struct packed {
    logic               done;
    logic               ramp;
    logic [PROD_W-1:0]  p_prop;
    logic [PROD_W-1:0]  p_integ;
    logic [DPROD_W-1:0] p_deriv;
    logic [DRIFT_W-1:0] p_drift;
  } prod_t;

  // Clamp a 33-bit signed value to the signed 32-bit range
  function automatic logic [POS_W-1:0] sat32(input logic [POS_W:0] v);
    logic [POS_W-1:0] r;
    if (v[POS_W] != v[POS_W-1]) begin
      r = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  // Clamp a wide signed value to the signed 16-bit range
  function automatic logic [SPD_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
    logic [SPD_W-1:0] r;
    if (v > SUM_W'(signed'(32'sd32767))) begin
      r = 16'h7fff;
    end else if (v < SUM_W'(signed'(-32'sd32768))) begin
      r = 16'h8000;
    end else begin
      r = v[SPD_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/pdc_if.sv
// Channel interfaces of the PID drive controller: encoder ticks in, speed commands out.
// Depends on pdc_pkg for field widths.
interface pdc_tick_if;
  import pdc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] left_position;
  logic signed [POS_W-1:0] right_position;
  modport source (output valid, left_position, right_position, input ready);
  modport sink   (input valid, left_position, right_position, output ready);
endinterface

interface pdc_cmd_if;
  import pdc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SPD_W-1:0] left_speed;
  logic signed [SPD_W-1:0] right_speed;
  logic                    move_done;
  modport source (output valid, left_speed, right_speed, move_done, input ready);
  modport sink   (input valid, left_speed, right_speed, move_done, output ready);
endinterface

### rtl/core/pdc_cfg_regs.sv
// Configuration register file of the PID drive controller.
// Depends on pdc_pkg; flags a rearm on every target write.
module pdc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pdc_pkg::CFG_DATA_W-1:0] cfg_data,
  output pdc_pkg::cfg_t                  cfg,
  output logic                           rearm
);
  import pdc_pkg::*;

  // Take register writes; unused indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode       <= MODE_DRIVE;
      cfg.target     <= '0;
      cfg.prop_gain  <= PROP_GAIN_RST;
      cfg.integ_gain <= INTEG_GAIN_RST;
      cfg.deriv_gain <= DERIV_GAIN_RST;
      cfg.integ_zone <= INTEG_ZONE_RST;
      cfg.drift_gain <= DRIFT_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE:       cfg.mode       <= cfg_data[0];
        REG_TARGET:     cfg.target     <= cfg_data[TGT_W-1:0];
        REG_PROP_GAIN:  cfg.prop_gain  <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN: cfg.integ_gain <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN: cfg.deriv_gain <= cfg_data[GAIN_W-1:0];
        REG_INTEG_ZONE: cfg.integ_zone <= cfg_data[ZONE_W-1:0];
        REG_DRIFT_GAIN: cfg.drift_gain <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Flag the rearm in the cycle after a target write, once the new target is held
  always_ff @(posedge clk) begin
    if (rst) begin
      rearm <= 1'b0;
    end else begin
      rearm <= cfg_we && (cfg_reg_t'(cfg_index) == REG_TARGET);
    end
  end

endmodule

### rtl/core/pdc_err_stage.sv
// Input register and error stage: error, ramp decision, integral and derivative terms.
// Depends on pdc_pkg and pdc_tick_if; owns last_error, error_sum and the armed flag.
module pdc_err_stage (
  input  logic          clk,
  input  logic          rst,
  input  pdc_pkg::cfg_t cfg,
  input  logic          rearm,
  pdc_tick_if.sink      tick,
  output logic          err_valid,
  input  logic          err_ready,
  output pdc_pkg::err_t err_q
);
  import pdc_pkg::*;

  logic                    in_valid;
  logic signed [POS_W-1:0] lp;
  logic signed [POS_W-1:0] rp;
  logic                    err_take;
  logic                    adv;

  logic signed [POS_W-1:0] last_error;
  logic signed [POS_W-1:0] error_sum;
  logic                    armed;

  logic signed [POS_W:0]   raw_err;
  logic signed [POS_W-1:0] err;
  logic [POS_W-1:0]        abs_err;
  logic                    done;
  logic                    ramp;
  logic signed [POS_W:0]   err_delta;
  logic signed [POS_W-1:0] err_sum_next;
  logic signed [POS_W:0]   drift_raw;
  logic [POS_W:0]          drift_abs;

  // Handshake: the error register takes a transaction when empty or draining
  assign err_take  = !err_valid || err_ready;
  assign adv       = in_valid && err_take;
  assign tick.ready = !in_valid || err_take;

  // Capture encoder positions
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      lp <= tick.left_position;
      rp <= tick.right_position;
    end
  end

  // Error, ramp decision and integral update
  always_comb begin
    raw_err = (POS_W+1)'($signed(cfg.target)) - (POS_W+1)'(lp);
    err     = $signed(sat32(raw_err));
    abs_err = err[POS_W-1] ? (~err + 1'b1) : err;
    done    = !armed || (err == '0);
    if (cfg.mode == MODE_DRIVE) begin
      ramp = abs_err > POS_W'(DRIVE_THRESH);
    end else begin
      ramp = err > POS_W'(signed'(TURN_THRESH));
    end
    err_delta = (POS_W+1)'(err) - (POS_W+1)'(last_error);
    if (abs_err < POS_W'(cfg.integ_zone)) begin
      err_sum_next = $signed(sat32((POS_W+1)'(error_sum) + (POS_W+1)'(err)));
    end else begin
      err_sum_next = '0;
    end
    drift_raw = (POS_W+1)'(lp) - (POS_W+1)'(rp);
    drift_abs = drift_raw[POS_W] ? (~drift_raw + 1'b1) : drift_raw;
  end

  // Advance controller state as each transaction leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      error_sum  <= '0;
      armed      <= 1'b1;
    end else if (rearm) begin
      last_error <= POS_W'($signed(cfg.target));
      error_sum  <= '0;
      armed      <= 1'b1;
    end else if (adv) begin
      if (done) begin
        armed <= 1'b0;
      end else if (!ramp) begin
        last_error <= err;
        error_sum  <= err_sum_next;
      end
    end
  end

  // Hold the stage result for the product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      err_valid <= 1'b0;
    end else if (err_take) begin
      err_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      err_q.done      <= done;
      err_q.ramp      <= ramp;
      err_q.err       <= err;
      err_q.err_sum   <= err_sum_next;
      err_q.err_delta <= err_delta;
      err_q.drift_abs <= drift_abs;
    end
  end

endmodule

### rtl/core/pdc_mul_stage.sv
// Product stage: gain multiplications for the PID and drift terms.
// Depends on pdc_pkg; one multiplier per term, each followed by a register.
module pdc_mul_stage (
  input  logic           clk,
  input  logic           rst,
  input  pdc_pkg::cfg_t  cfg,
  input  logic           err_valid,
  output logic           err_ready,
  input  pdc_pkg::err_t  err_q,
  output logic           prod_valid,
  input  logic           prod_ready,
  output pdc_pkg::prod_t prod_q
);
  import pdc_pkg::*;

  logic                      adv;
  logic signed [PROD_W-1:0]  p_prop;
  logic signed [PROD_W-1:0]  p_integ;
  logic signed [DPROD_W-1:0] p_deriv;
  logic [DRIFT_W-1:0]        p_drift;

  assign err_ready = !prod_valid || prod_ready;
  assign adv       = err_valid && err_ready;

  // Form the four products
  always_comb begin
    p_prop  = PROD_W'($signed({1'b0, cfg.prop_gain})) * PROD_W'($signed(err_q.err));
    p_integ = PROD_W'($signed({1'b0, cfg.integ_gain})) * PROD_W'($signed(err_q.err_sum));
    p_deriv = DPROD_W'($signed({1'b0, cfg.deriv_gain})) *
              DPROD_W'($signed(err_q.err_delta));
    p_drift = DRIFT_W'(cfg.drift_gain) * DRIFT_W'(err_q.drift_abs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (err_ready) begin
      prod_valid <= err_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_q.done    <= err_q.done;
      prod_q.ramp    <= err_q.ramp;
      prod_q.p_prop  <= p_prop;
      prod_q.p_integ <= p_integ;
      prod_q.p_deriv <= p_deriv;
      prod_q.p_drift <= p_drift;
    end
  end

endmodule

### rtl/core/pdc_out_stage.sv
// Output stage: PID sum and rounding, speed ramp, drift split and saturation.
// Depends on pdc_pkg and pdc_cmd_if; owns ramp_speed and the result register.
module pdc_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  pdc_pkg::cfg_t  cfg,
  input  logic           rearm,
  input  logic           prod_valid,
  output logic           prod_ready,
  input  pdc_pkg::prod_t prod_q,
  pdc_cmd_if.source      cmd
);
  import pdc_pkg::*;

  localparam int RAMP_W = SPD_W + 2;
  localparam int DIFF_W = DRIFT_W + 1 - FRAC_SHIFT;

  logic                          adv;
  logic signed [SPD_W-1:0]       ramp_speed;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       acc_rnd;
  logic signed [SPD_WIDE_W-1:0]  pid_spd;
  logic signed [RAMP_W-1:0]      ramp_up;
  logic signed [RAMP_W-1:0]      ramp_dn;
  logic signed [RAMP_W-1:0]      ramp_spd;
  logic signed [RAMP_W-1:0]      cap;
  logic signed [SPD_WIDE_W-1:0]  spd;
  logic [DRIFT_W:0]              drift_rnd;
  logic [DIFF_W-1:0]             diff;
  logic signed [SUM_W-1:0]       l_sum;
  logic signed [SUM_W-1:0]       r_sum;
  logic                          tgt_pos;
  logic signed [SPD_W-1:0]       l_spd;
  logic signed [SPD_W-1:0]       r_spd;

  assign prod_ready = !cmd.valid || cmd.ready;
  assign adv        = prod_valid && prod_ready;
  assign tgt_pos    = $signed(cfg.target) > $signed(TGT_W'(0));

  always_comb begin
    // PID sum, rounded half up to Q8.8
    acc     = ACC_W'($signed(prod_q.p_prop)) + ACC_W'($signed(prod_q.p_integ)) +
              ACC_W'($signed(prod_q.p_deriv));
    acc_rnd = acc + ACC_W'(ROUND_HALF);
    pid_spd = acc_rnd[ACC_W-1:FRAC_SHIFT];

    // Ramp toward the mode's cap
    cap     = (cfg.mode == MODE_DRIVE) ? RAMP_W'(DRIVE_CAP) : RAMP_W'(TURN_CAP);
    ramp_up = RAMP_W'(ramp_speed) + RAMP_W'(RAMP_STEP_Q);
    ramp_dn = RAMP_W'(ramp_speed) - RAMP_W'(RAMP_STEP_Q);
    if (tgt_pos) begin
      ramp_spd = (ramp_up >= cap) ? cap : ramp_up;
    end else begin
      ramp_spd = (ramp_dn <= -cap) ? -cap : ramp_dn;
    end
    spd = prod_q.ramp ? SPD_WIDE_W'(ramp_spd) : pid_spd;

    // Drift correction, rounded the same way
    drift_rnd = (DRIFT_W+1)'(prod_q.p_drift) + (DRIFT_W+1)'(ROUND_HALF);
    diff      = drift_rnd[DRIFT_W:FRAC_SHIFT];

    // Split into the two sides and saturate
    if (cfg.mode == MODE_DRIVE) begin
      if (tgt_pos) begin
        l_sum = SUM_W'(spd) + SUM_W'(diff);
        r_sum = SUM_W'(spd) - SUM_W'(diff);
      end else begin
        l_sum = SUM_W'(spd);
        r_sum = SUM_W'(spd);
      end
      l_spd = $signed(sat16(l_sum));
      r_spd = $signed(sat16(r_sum));
    end else begin
      l_sum = SUM_W'(spd);
      r_sum = '0;
      l_spd = $signed(sat16(l_sum));
      r_spd = $signed(sat16(-SUM_W'(l_spd)));
    end
  end

  // Remember the last left speed for the ramp
  always_ff @(posedge clk) begin
    if (rst || rearm) begin
      ramp_speed <= '0;
    end else if (adv && !prod_q.done) begin
      ramp_speed <= l_spd;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
    end else if (prod_ready) begin
      cmd.valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (prod_q.done) begin
        cmd.left_speed  <= '0;
        cmd.right_speed <= '0;
        cmd.move_done   <= 1'b1;
      end else begin
        cmd.left_speed  <= l_spd;
        cmd.right_speed <= r_spd;
        cmd.move_done   <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/pid_drive_controller_unit.sv
// Top level of the PID drive controller: config registers and the three-stage datapath.
// Depends on pdc_pkg, pdc_if, pdc_cfg_regs, pdc_err_stage, pdc_mul_stage, pdc_out_stage.
//
// Usage:
//   tick carries one control tick (left and right encoder positions) per transaction;
//   cmd returns one transaction per tick: left and right speed in Q8.8 percent and
//   move_done. Both channels use valid/ready; a transaction moves when both are high.
//   Registers are written via cfg_we/cfg_index/cfg_data, one per clock; the user must
//   do so only while no tick is in flight (not enforced). Writing the target rearms it.
// Timing:
//   A tick accepted by the input register passes through the error stage, product
//   stage and result register before it shows on cmd. One tick per cycle is
//   sustained while cmd is taken; the rate is set by the error stage, which must finish
//   updating the integral and derivative state of one tick before the next tick arrives.
// Reset:
//   rst (synchronous, active high) empties the pipeline, loads the default gains,
//   clears the controller state and arms the controller with a target of zero.
// Stall:
//   When cmd is not taken, each stage holds its transaction and the pipeline keeps
//   accepting ticks until every stage is full; tick.ready then drops.
module pid_drive_controller_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pdc_pkg::CFG_DATA_W-1:0] cfg_data,
  pdc_tick_if.sink                       tick,
  pdc_cmd_if.source                      cmd
);
  import pdc_pkg::*;

  cfg_t  cfg;
  logic  rearm;
  logic  err_valid;
  logic  err_ready;
  err_t  err_q;
  logic  prod_valid;
  logic  prod_ready;
  prod_t prod_q;

  pdc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .rearm     (rearm)
  );

  pdc_err_stage u_err (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rearm     (rearm),
    .tick      (tick),
    .err_valid (err_valid),
    .err_ready (err_ready),
    .err_q     (err_q)
  );

  pdc_mul_stage u_mul (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .err_valid  (err_valid),
    .err_ready  (err_ready),
    .err_q      (err_q),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod_q     (prod_q)
  );

  pdc_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .rearm      (rearm),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod_q     (prod_q),
    .cmd        (cmd)
  );

endmodule

### bench/pid_drive_controller_unit_tb.sv
// Self-checking bench for pid_drive_controller_unit: directed drill table and random moves,
// each command checked against the table's expected value or a cycle-free controller model.
// Depends on pdc_pkg, pdc_if (pdc_tick_if, pdc_cmd_if) and the block's RTL.
module pid_drive_controller_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pdc_pkg::*;

  localparam int RANDOM_TICKS = 1750;
  localparam int MAX_WAIT     = 11;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE       = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  localparam longint ERR_MIN = -64'sd2147483648;
  localparam longint ERR_MAX = 64'sd2147483647;
  localparam longint SPD_MIN = -64'sd32768;
  localparam longint SPD_MAX = 64'sd32767;

  typedef struct {
    logic signed [SPD_W-1:0] left_speed;
    logic signed [SPD_W-1:0] right_speed;
    logic                    move_done;
  } speed_cmd_t;

  typedef struct {
    bit                      is_write;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   data;
    logic signed [POS_W-1:0] lp;
    logic signed [POS_W-1:0] rp;
    bit                      typed;
    speed_cmd_t              want;
  } drill_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pdc_tick_if tick_ch ();
  pdc_cmd_if  cmd_ch ();

  pid_drive_controller_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .cmd       (cmd_ch)
  );

  // Controller model state and live settings
  logic                    ctl_mode;
  logic signed [TGT_W-1:0] ctl_target;
  logic [GAIN_W-1:0]       ctl_prop;
  logic [GAIN_W-1:0]       ctl_integ;
  logic [GAIN_W-1:0]       ctl_deriv;
  logic [GAIN_W-1:0]       ctl_drift;
  logic [ZONE_W-1:0]       ctl_zone;
  logic signed [POS_W-1:0] ctl_last_err;
  logic signed [POS_W-1:0] ctl_err_sum;
  logic signed [SPD_W-1:0] ctl_ramp;
  bit                      ctl_armed;

  speed_cmd_t owed_speeds[$];
  drill_row_t drill_rows[$];
  int         sent;
  int         bad;
  int         cycles;
  bit         no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up on a hung block
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("pid_drive_controller_unit_tb: done, errors");
    $finish;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Round 20 fraction bits to Q8.8, ties toward plus infinity
  function automatic longint q88_round(longint x);
    return (x + ROUND_HALF) >>> FRAC_SHIFT;
  endfunction

  task automatic reset_controller();
    ctl_mode     = MODE_DRIVE;
    ctl_target   = '0;
    ctl_prop     = PROP_GAIN_RST;
    ctl_integ    = INTEG_GAIN_RST;
    ctl_deriv    = DERIV_GAIN_RST;
    ctl_zone     = INTEG_ZONE_RST;
    ctl_drift    = DRIFT_GAIN_RST;
    ctl_last_err = '0;
    ctl_err_sum  = '0;
    ctl_ramp     = '0;
    ctl_armed    = 1'b1;
  endtask

  task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_MODE:       ctl_mode = data[0];
      REG_TARGET: begin
        // A new target rearms the move
        ctl_target   = data[TGT_W-1:0];
        ctl_last_err = POS_W'(ctl_target);
        ctl_err_sum  = '0;
        ctl_ramp     = '0;
        ctl_armed    = 1'b1;
      end
      REG_PROP_GAIN:  ctl_prop  = data[GAIN_W-1:0];
      REG_INTEG_GAIN: ctl_integ = data[GAIN_W-1:0];
      REG_DERIV_GAIN: ctl_deriv = data[GAIN_W-1:0];
      REG_INTEG_ZONE: ctl_zone  = data[ZONE_W-1:0];
      REG_DRIFT_GAIN: ctl_drift = data[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // One control tick: work out both speed commands and advance the model state
  function automatic speed_cmd_t drive_step(logic signed [POS_W-1:0] lp,
                                            logic signed [POS_W-1:0] rp);
    speed_cmd_t c;
    longint     tgt, e, mag, spd, l, r, cap, de;
    bit         ramp;
    tgt = ctl_target;
    e   = clamp(tgt - longint'(lp), ERR_MIN, ERR_MAX);
    mag = (e < 0) ? -e : e;
    c.left_speed  = '0;
    c.right_speed = '0;
    c.move_done   = 1'b1;
    // Zero error finishes the move; a finished move keeps reporting done
    if (!ctl_armed || e == 0) begin
      ctl_armed = 1'b0;
      return c;
    end
    if (ctl_mode == MODE_DRIVE) begin
      ramp = mag > DRIVE_THRESH;
      cap  = DRIVE_CAP;
    end else begin
      ramp = e > TURN_THRESH;
      cap  = TURN_CAP;
    end
    if (ramp) begin
      // Ramp toward the cap, PID state untouched
      if (tgt > 0) begin
        spd = longint'(ctl_ramp) + RAMP_STEP_Q;
        if (spd >= cap) spd = cap;
      end else begin
        spd = longint'(ctl_ramp) - RAMP_STEP_Q;
        if (spd <= -cap) spd = -cap;
      end
    end else begin
      de = e - longint'(ctl_last_err);
      ctl_last_err = e[POS_W-1:0];
      if (mag < longint'(ctl_zone)) begin
        ctl_err_sum = POS_W'(clamp(longint'(ctl_err_sum) + e, ERR_MIN, ERR_MAX));
      end else begin
        ctl_err_sum = '0;
      end
      spd = q88_round(longint'(ctl_prop) * e + longint'(ctl_integ) * longint'(ctl_err_sum)
                      + longint'(ctl_deriv) * de);
    end
    if (ctl_mode == MODE_DRIVE) begin
      l = spd;
      r = spd;
      // Drift correction only for a forward move
      if (tgt > 0) begin
        de = longint'(lp) - longint'(rp);
        if (de < 0) de = -de;
        de = q88_round(longint'(ctl_drift) * de);
        l  = l + de;
        r  = r - de;
      end
      l = clamp(l, SPD_MIN, SPD_MAX);
      r = clamp(r, SPD_MIN, SPD_MAX);
    end else begin
      l = clamp(spd, SPD_MIN, SPD_MAX);
      r = clamp(-l, SPD_MIN, SPD_MAX);
    end
    ctl_ramp      = l[SPD_W-1:0];
    c.left_speed  = l[SPD_W-1:0];
    c.right_speed = r[SPD_W-1:0];
    c.move_done   = 1'b0;
    return c;
  endfunction

  // Drill table entries
  task automatic add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drill_row_t row;
    row          = '{default: '0};
    row.is_write = 1'b1;
    row.idx      = idx;
    row.data     = data;
    drill_rows.push_back(row);
  endtask

  task automatic add_tick(logic signed [POS_W-1:0] lp, logic signed [POS_W-1:0] rp);
    drill_row_t row;
    row    = '{default: '0};
    row.lp = lp;
    row.rp = rp;
    drill_rows.push_back(row);
  endtask

  task automatic add_check(logic signed [POS_W-1:0] lp, logic signed [POS_W-1:0] rp,
                           logic signed [SPD_W-1:0] l, logic signed [SPD_W-1:0] r,
                           logic d);
    drill_row_t row;
    row                  = '{default: '0};
    row.lp               = lp;
    row.rp               = rp;
    row.typed            = 1'b1;
    row.want.left_speed  = l;
    row.want.right_speed = r;
    row.want.move_done   = d;
    drill_rows.push_back(row);
  endtask

  task automatic build_drill();
    // Zero error straight out of reset, then a finished move
    add_check(0, 0, 0, 0, 1'b1);
    add_check(123, -77, 0, 0, 1'b1);
    // Forward ramp up to the drive cap
    add_write(REG_TARGET, 24'd1000);
    add_check(0, 0, 5120, 5120, 1'b0);
    add_check(0, 0, 10240, 10240, 1'b0);
    add_check(0, 0, 15360, 15360, 1'b0);
    add_check(0, 0, 20480, 20480, 1'b0);
    add_check(0, 0, 20480, 20480, 1'b0);
    add_tick(0, 40);
    // PID region, then inside the integral zone
    add_tick(700, 690);
    add_tick(995, 1000);
    add_tick(997, 997);
    // Mode change mid-move, then land on the target
    add_write(REG_MODE, 24'd1);
    add_tick(998, 0);
    add_check(1000, 5, 0, 0, 1'b1);
    // Speed saturation both ways, drive and turn
    add_write(REG_PROP_GAIN, 24'hFFFFFF);
    add_write(REG_TARGET, 24'd1000);
    add_write(REG_MODE, 24'd0);
    add_check(600, 600, 32767, 32767, 1'b0);
    add_check(1400, 1400, -32768, -32768, 1'b0);
    add_write(REG_MODE, 24'd1);
    add_check(1400, 0, -32768, 32767, 1'b0);
    add_write(REG_TARGET, 24'd2000);
    add_check(0, 0, 5120, -5120, 1'b0);
    // Error clamped to 32 bits at both target extremes
    add_write(REG_TARGET, 24'h100000);
    add_write(REG_MODE, 24'd0);
    add_check(32'h7fffffff, 32'h80000000, -5120, -5120, 1'b0);
    add_write(REG_TARGET, 24'h0FFFFF);
    add_write(REG_DRIFT_GAIN, 24'hFFFFFF);
    add_check(32'h80000000, 32'h7fffffff, 32767, -32768, 1'b0);
    // Integral and derivative at full gain, widest and empty zone
    add_write(REG_PROP_GAIN, 24'd0);
    add_write(REG_INTEG_GAIN, 24'hFFFFFF);
    add_write(REG_DERIV_GAIN, 24'hFFFFFF);
    add_write(REG_INTEG_ZONE, 24'h00FFFF);
    add_write(REG_DRIFT_GAIN, 24'd0);
    add_write(REG_SPARE, 24'hFFFFFF);
    add_tick(1048570, 0);
    add_tick(1048574, 3);
    add_write(REG_INTEG_ZONE, 24'd0);
    add_tick(1048573, 0);
    // Unused upper data bits are dropped
    add_write(REG_MODE, 24'hFFFFFE);
    add_write(REG_TARGET, 24'hE00000);
    add_check(0, 0, 0, 0, 1'b1);
  endtask

  // Hold off until every command owed has come back
  task automatic wait_idle();
    tick_ch.valid <= 1'b0;
    while (owed_speeds.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one tick, wait for the transaction and queue the command it owes
  task automatic push_tick(logic signed [POS_W-1:0] lp, logic signed [POS_W-1:0] rp,
                           bit typed, speed_cmd_t want);
    int         gap;
    speed_cmd_t got;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid          <= 1'b1;
    tick_ch.left_position  <= lp;
    tick_ch.right_position <= rp;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    got = drive_step(lp, rp);
    owed_speeds.push_back(typed ? want : got);
    sent++;
  endtask

  function automatic logic [GAIN_W-1:0] draw_gain(int typical);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(0, typical));
    endcase
  endfunction

  function automatic logic [ZONE_W-1:0] draw_zone();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return ZONE_W'($urandom);
      default: return ZONE_W'($urandom_range(0, 300));
    endcase
  endfunction

  function automatic logic signed [TGT_W-1:0] draw_target();
    case ($urandom_range(0, 11))
      0:       return {1'b1, {(TGT_W-1){1'b0}}};
      1:       return {1'b0, {(TGT_W-1){1'b1}}};
      2:       return '0;
      3:       return TGT_W'($urandom);
      default: return TGT_W'(int'($urandom_range(0, 8000)) - 4000);
    endcase
  endfunction

  // One move: new settings, then encoder positions closing in on the target
  task automatic random_move();
    longint                  pos, err;
    int                      skew;
    logic signed [POS_W-1:0] lp, rp;
    speed_cmd_t              none;
    none    = '{default: '0};
    no_idle = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 1) == 0) write_reg(REG_MODE, CFG_DATA_W'($urandom));
    if ($urandom_range(0, 2) == 0) write_reg(REG_PROP_GAIN, draw_gain(1 << 19));
    if ($urandom_range(0, 2) == 0) write_reg(REG_INTEG_GAIN, draw_gain(1 << 13));
    if ($urandom_range(0, 2) == 0) write_reg(REG_DERIV_GAIN, draw_gain(1 << 19));
    if ($urandom_range(0, 2) == 0) write_reg(REG_INTEG_ZONE, {8'($urandom), draw_zone()});
    if ($urandom_range(0, 2) == 0) write_reg(REG_DRIFT_GAIN, draw_gain(1 << 18));
    if ($urandom_range(0, 15) == 0) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    if ($urandom_range(0, 7) != 0) write_reg(REG_TARGET, {3'($urandom), draw_target()});
    pos  = ($urandom_range(0, 5) == 0) ? longint'(int'($urandom_range(0, 4000)) - 2000) : 0;
    skew = int'($urandom_range(0, 40)) - 20;
    if ($urandom_range(0, 3) == 0) skew = int'($urandom_range(0, 4000)) - 2000;
    repeat ($urandom_range(6, 40)) begin
      if ($urandom_range(0, 9) == 0) begin
        // Noise: any encoder values at all
        lp = $urandom;
        rp = $urandom;
      end else begin
        err = longint'(ctl_target) - pos;
        if (err > 600 || err < -600) begin
          pos = pos + err / int'($urandom_range(2, 6));
        end else begin
          case ($urandom_range(0, 5))
            0:       pos = longint'(ctl_target);
            1, 2:    pos = pos + err / 2;
            default: pos = pos + (int'($urandom_range(0, 8)) - 4);
          endcase
        end
        lp = pos[POS_W-1:0];
        rp = lp + skew + (int'($urandom_range(0, 4)) - 2);
      end
      push_tick(lp, rp, 1'b0, none);
    end
  endtask

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      bad++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Command sink: random stalls, check each transaction against the oldest owed command
  initial begin
    int         stall;
    speed_cmd_t w;
    cmd_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        cmd_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      cmd_ch.ready <= 1'b1;
      @(posedge clk);
      while (!cmd_ch.valid) @(posedge clk);
      if (owed_speeds.size() == 0) begin
        bad++;
        $error("command with no tick outstanding: left %0d right %0d done %0b",
               cmd_ch.left_speed, cmd_ch.right_speed, cmd_ch.move_done);
      end else begin
        w = owed_speeds.pop_front();
        compare_field("left_speed", w.left_speed, cmd_ch.left_speed);
        compare_field("right_speed", w.right_speed, cmd_ch.right_speed);
        compare_field("move_done", w.move_done, cmd_ch.move_done);
      end
    end
  end

  // Tick source and register writes
  initial begin
    rst                    <= 1'b1;
    cfg_we                 <= 1'b0;
    cfg_index              <= '0;
    cfg_data               <= '0;
    tick_ch.valid          <= 1'b0;
    tick_ch.left_position  <= '0;
    tick_ch.right_position <= '0;
    no_idle = 1'b0;
    sent    = 0;
    bad     = 0;
    reset_controller();
    build_drill();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the drill table
    foreach (drill_rows[i]) begin
      if (drill_rows[i].is_write) begin
        write_reg(drill_rows[i].idx, drill_rows[i].data);
      end else begin
        push_tick(drill_rows[i].lp, drill_rows[i].rp, drill_rows[i].typed,
                  drill_rows[i].want);
      end
    end

    sent = 0;
    while (sent < RANDOM_TICKS) random_move();

    // Drain and let the pipeline settle
    wait_idle();
    repeat (SETTLE) @(posedge clk);
    if (bad == 0) begin
      $display("pid_drive_controller_unit_tb: done, clean");
    end else begin
      $display("pid_drive_controller_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/pdc_pkg.sv
rtl/core/pdc_if.sv
rtl/core/pdc_cfg_regs.sv
rtl/core/pdc_err_stage.sv
rtl/core/pdc_mul_stage.sv
rtl/core/pdc_out_stage.sv
rtl/core/pid_drive_controller_unit.sv
bench/pid_drive_controller_unit_tb.sv
